@@ rtl/sequential_list_engine_defines.svh @@
`ifndef SEQUENTIAL_LIST_ENGINE_DEFINES_SVH
`define SEQUENTIAL_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted
`define SLE_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("sle check failed");

// Next-cycle implication
`define SLE_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("sle check failed");

`endif

@@ rtl/sle_pkg.sv @@
package sle_pkg;

	localparam int DEPTH      = 16;
	localparam int ELEM_WIDTH = 32;
	localparam int CNT_W      = $clog2(DEPTH + 1);

	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	// command codes
	localparam logic [2:0] CMD_INS_HEAD = 3'd0;
	localparam logic [2:0] CMD_INS_TAIL = 3'd1;
	localparam logic [2:0] CMD_INS_AT   = 3'd2;
	localparam logic [2:0] CMD_REM_HEAD = 3'd3;
	localparam logic [2:0] CMD_REM_TAIL = 3'd4;
	localparam logic [2:0] CMD_REM_AT   = 3'd5;
	localparam logic [2:0] CMD_SEARCH   = 3'd6;
	localparam logic [2:0] CMD_CLEAR    = 3'd7;

	// per-cell operation codes
	localparam logic [1:0] CELL_HOLD = 2'd0;
	localparam logic [1:0] CELL_UP   = 2'd1;
	localparam logic [1:0] CELL_DOWN = 2'd2;
	localparam logic [1:0] CELL_LOAD = 2'd3;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [4:0]  position;
		logic [31:0] value;
	} sle_in_t;

	typedef struct packed {
		logic       ok;
		logic [4:0] found_position;
		logic [4:0] count;
		logic       is_full;
		logic       is_empty;
	} sle_out_t;

	typedef struct packed {
		logic       en;    // capture match flag
		logic       live;  // entry below the count
		logic [1:0] op;
	} sle_cell_ctl_t;

endpackage

@@ rtl/sequential_list_engine.sv @@
// Fixed-capacity ordered list held in a row of sixteen 32-bit cells. At the accept edge of a
// command word every cell shifts, loads or holds and latches its compare flag; later, once the
// output register is free or being read, the first match is encoded and the result lands in the
// output register. in_ready stays low from the accept until that result is written, and so
// also while an older result waits there for out_ready. capacity (cfg_we/cfg_wdata)
// saturates at sixteen; lowering it under the count drops nothing, the list just reports full.
module sequential_list_engine
	import sle_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  sle_in_t    in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output sle_out_t   out_data,
	input  logic       cfg_we,
	input  logic [4:0] cfg_wdata
);

	logic [4:0]       capacity_q;
	logic [CNT_W-1:0] count_q;
	logic             busy_q;
	logic             ok_s1;
	logic             search_s1;
	logic             out_valid_q;
	sle_out_t         out_q;

	logic                  accept;
	logic                  finish;
	logic [CNT_W-1:0]      eff_cap;
	logic                  full_now;
	logic                  ok_now;
	logic [CNT_W-1:0]      count_nx;
	logic                  do_ins;
	logic                  do_rem;
	logic [CNT_W-1:0]      idx;
	logic [ELEM_WIDTH-1:0] elem;
	logic [DEPTH-1:0]      match_vec;
	logic [4:0]            found_pos;
	logic                  found_any;
	logic [ELEM_WIDTH-1:0] cell_data [DEPTH];

	assign accept = in_valid && in_ready;
	assign finish = busy_q && (!out_valid_q || out_ready);
	assign elem   = in_data.value[ELEM_WIDTH-1:0];

	assign eff_cap  = ({1'b0, capacity_q} > (CNT_W + 1)'(DEPTH)) ? DEPTH_C
	                                                             : CNT_W'(capacity_q);
	assign full_now = count_q >= eff_cap;

	always_comb begin
		ok_now   = 1'b0;
		do_ins   = 1'b0;
		do_rem   = 1'b0;
		idx      = '0;
		count_nx = count_q;
		unique case (in_data.cmd)
			CMD_INS_HEAD: begin
				ok_now = !full_now;
				do_ins = ok_now;
			end
			CMD_INS_TAIL: begin
				ok_now = !full_now;
				do_ins = ok_now;
				idx    = count_q;
			end
			CMD_INS_AT: begin
				ok_now = !full_now && (in_data.position != 5'd0) &&
				         ({1'b0, in_data.position} <= 6'(count_q) + 6'd1);
				do_ins = ok_now;
				idx    = CNT_W'(in_data.position - 5'd1);
			end
			CMD_REM_HEAD: begin
				ok_now = count_q != '0;
				do_rem = ok_now;
			end
			CMD_REM_TAIL: begin
				ok_now = count_q != '0;
			end
			CMD_REM_AT: begin
				ok_now = (count_q != '0) && (in_data.position != 5'd0) &&
				         (6'(in_data.position) <= 6'(count_q));
				do_rem = ok_now;
				idx    = CNT_W'(in_data.position - 5'd1);
			end
			CMD_SEARCH: begin
				ok_now = 1'b0;
			end
			default: begin
				ok_now = 1'b1;
			end
		endcase
		if (in_data.cmd == CMD_CLEAR) begin
			count_nx = '0;
		end else if (do_ins) begin
			count_nx = count_q + CNT_W'(1);
		end else if (ok_now) begin
			count_nx = count_q - CNT_W'(1);
		end
	end

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			sle_cell_ctl_t         ctl;
			logic [ELEM_WIDTH-1:0] left_d;
			logic [ELEM_WIDTH-1:0] right_d;

			always_comb begin
				ctl.en   = accept;
				ctl.live = CNT_W'(g) < count_q;
				ctl.op   = CELL_HOLD;
				if (accept && do_ins) begin
					if (CNT_W'(g) == idx) begin
						ctl.op = CELL_LOAD;
					end else if (CNT_W'(g) > idx) begin
						ctl.op = CELL_UP;
					end
				end else if (accept && do_rem && (CNT_W'(g) >= idx)) begin
					ctl.op = CELL_DOWN;
				end
			end

			if (g == 0) begin : g_head
				assign left_d = elem;
			end else begin : g_mid
				assign left_d = cell_data[g-1];
			end
			if (g == DEPTH - 1) begin : g_last
				assign right_d = cell_data[g];
			end else begin : g_inner
				assign right_d = cell_data[g+1];
			end

			sle_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.value      (elem),
				.left_data  (left_d),
				.right_data (right_d),
				.data       (cell_data[g]),
				.match      (match_vec[g])
			);
		end
	endgenerate

	sle_find u_find (
		.match          (match_vec),
		.found_position (found_pos),
		.any            (found_any)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= 5'd16;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_nx;
				busy_q  <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_s1     <= ok_now;
			search_s1 <= in_data.cmd == CMD_SEARCH;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_q.ok             <= search_s1 ? found_any : ok_s1;
			out_q.found_position <= search_s1 ? found_pos : 5'd0;
			out_q.count          <= 5'(count_q);
			out_q.is_full        <= full_now;
			out_q.is_empty       <= count_q == '0;
		end
	end

	assign in_ready  = !busy_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ rtl/sle_cell.sv @@
module sle_cell
	import sle_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  sle_cell_ctl_t         ctl,
	input  logic [ELEM_WIDTH-1:0] value,
	input  logic [ELEM_WIDTH-1:0] left_data,
	input  logic [ELEM_WIDTH-1:0] right_data,
	output logic [ELEM_WIDTH-1:0] data,
	output logic                  match
);

	logic [ELEM_WIDTH-1:0] data_q;
	logic                  match_q;

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			CELL_UP:   data_q <= left_data;
			CELL_DOWN: data_q <= right_data;
			CELL_LOAD: data_q <= value;
			default:   data_q <= data_q;
		endcase
	end

	// compare against contents before this word's shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.en) begin
			match_q <= ctl.live && (data_q == value);
		end
	end

	assign data  = data_q;
	assign match = match_q;

endmodule

@@ rtl/sle_find.sv @@
module sle_find
	import sle_pkg::*;
(
	input  logic [DEPTH-1:0] match,
	output logic [4:0]       found_position,
	output logic             any
);

	always_comb begin
		found_position = 5'd0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (match[i]) begin
				found_position = 5'(i + 1);
			end
		end
	end

	assign any = |match;

endmodule

@@ rtl/sle_checker.sv @@
`include "sequential_list_engine_defines.svh"

module sle_checker
	import sle_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input sle_out_t out_data
);

	`SLE_ASSERT_NOW(a_empty_cnt, clk, arst_n, out_valid, out_data.is_empty == (out_data.count == 5'd0))
	`SLE_ASSERT_NOW(a_found_ok, clk, arst_n, out_valid && (out_data.found_position != 5'd0), out_data.ok && (out_data.found_position <= out_data.count))
	`SLE_ASSERT_NEXT(a_one_word, clk, arst_n, in_valid && in_ready, !in_ready)
	`SLE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind sequential_list_engine sle_checker u_sle_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

@@ verif/sequential_list_engine_tb.sv @@
`timescale 1ns / 1ps

module sequential_list_engine_tb;
	import sle_pkg::*;

	localparam int LIMIT_CYCLES = 500000;
	localparam int PHASE_WORDS  = 155;

	class list_scoreboard;
		logic [31:0] live_words [DEPTH];
		int unsigned n_live;
		logic [4:0]  cap_reg;
		sle_out_t    predicted_status [$];
		int          errors;
		int          n_checked;
		int          n_ok;
		int          n_full;
		int          n_empty;

		function new();
			foreach (live_words[i]) live_words[i] = '0;
			n_live    = 0;
			cap_reg   = 5'd16;
			errors    = 0;
			n_checked = 0;
			n_ok      = 0;
			n_full    = 0;
			n_empty   = 0;
		endfunction

		function void set_capacity(logic [4:0] v);
			cap_reg = v;
		endfunction

		function int pending();
			return predicted_status.size();
		endfunction

		function logic [31:0] live_value();
			return live_words[$urandom_range(n_live - 1)];
		endfunction

		function void insert_word(int unsigned idx, logic [31:0] v);
			for (int unsigned i = n_live; i > idx; i--) begin
				if (i < DEPTH)
					live_words[i] = live_words[i - 1];
			end
			if (idx < DEPTH)
				live_words[idx] = v;
			n_live++;
		endfunction

		function void remove_word(int unsigned idx);
			for (int unsigned i = idx; i + 1 < n_live && i + 1 < DEPTH; i++)
				live_words[i] = live_words[i + 1];
			n_live--;
		endfunction

		function sle_out_t apply_command(sle_in_t w);
			sle_out_t    r;
			int unsigned eff;
			bit          full_now;
			r        = '0;
			eff      = (cap_reg > DEPTH) ? DEPTH : cap_reg;
			full_now = (n_live >= eff);
			case (w.cmd)
				CMD_INS_HEAD: if (!full_now) begin
					insert_word(0, w.value);
					r.ok = 1'b1;
				end
				CMD_INS_TAIL: if (!full_now) begin
					insert_word(n_live, w.value);
					r.ok = 1'b1;
				end
				CMD_INS_AT: if (!full_now && w.position >= 1 && w.position <= n_live + 1) begin
					insert_word(w.position - 1, w.value);
					r.ok = 1'b1;
				end
				CMD_REM_HEAD: if (n_live > 0) begin
					remove_word(0);
					r.ok = 1'b1;
				end
				// tail removal only moves the count
				CMD_REM_TAIL: if (n_live > 0) begin
					n_live--;
					r.ok = 1'b1;
				end
				CMD_REM_AT: if (n_live > 0 && w.position >= 1 && w.position <= n_live) begin
					remove_word(w.position - 1);
					r.ok = 1'b1;
				end
				CMD_SEARCH: begin
					for (int unsigned i = 0; i < n_live && i < DEPTH; i++) begin
						if (live_words[i] == w.value) begin
							r.found_position = 5'(i + 1);
							r.ok = 1'b1;
							break;
						end
					end
				end
				CMD_CLEAR: begin
					n_live = 0;
					r.ok = 1'b1;
				end
				default: ;
			endcase
			r.count    = 5'(n_live);
			r.is_full  = (n_live >= eff);
			r.is_empty = (n_live == 0);
			return r;
		endfunction

		function void note_command(sle_in_t w);
			predicted_status.push_back(apply_command(w));
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			if (errors <= 40)
				$display("mismatch %0d at result %0d: %s got %0h want %0h",
					errors, n_checked, what, got, want);
		endtask

		task check_status(sle_out_t got);
			sle_out_t want;
			if (predicted_status.size() == 0) begin
				report("unexpected result word", got, 0);
				return;
			end
			want = predicted_status.pop_front();
			if (got.ok !== want.ok)
				report("ok", got.ok, want.ok);
			if (got.found_position !== want.found_position)
				report("found_position", got.found_position, want.found_position);
			if (got.count !== want.count)
				report("count", got.count, want.count);
			if (got.is_full !== want.is_full)
				report("is_full", got.is_full, want.is_full);
			if (got.is_empty !== want.is_empty)
				report("is_empty", got.is_empty, want.is_empty);
			n_checked++;
			n_ok    += want.ok;
			n_full  += want.is_full;
			n_empty += want.is_empty;
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	sle_in_t    in_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	sle_out_t   out_data;
	logic       cfg_we = 1'b0;
	logic [4:0] cfg_wdata = '0;

	list_scoreboard sb;
	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	bit          rx_hold_req = 0;
	int          hold_left = 0;
	int          cycles = 0;
	logic [31:0] value_pool [8];

	sequential_list_engine DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver: random back-pressure, plus a long hold-off on request
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_status(out_data);
			if (rx_hold_req) begin
				hold_left = 400;
				rx_hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	function automatic sle_in_t cmd_word(logic [2:0] c, logic [4:0] p, logic [31:0] v);
		sle_in_t w;
		w.cmd      = c;
		w.position = p;
		w.value    = v;
		return w;
	endfunction

	// tidy words carry in-range positions and values likely to hit
	function automatic sle_in_t make_command(bit tidy);
		sle_in_t     w;
		int          r;
		int unsigned n;
		r = $urandom_range(99);
		n = sb.n_live;
		if (r < 15)      w.cmd = CMD_INS_HEAD;
		else if (r < 30) w.cmd = CMD_INS_TAIL;
		else if (r < 47) w.cmd = CMD_INS_AT;
		else if (r < 57) w.cmd = CMD_REM_HEAD;
		else if (r < 65) w.cmd = CMD_REM_TAIL;
		else if (r < 75) w.cmd = CMD_REM_AT;
		else if (r < 97) w.cmd = CMD_SEARCH;
		else             w.cmd = CMD_CLEAR;
		if (!tidy) begin
			w.position = 5'($urandom_range(31));
			w.value    = $urandom;
			return w;
		end
		if (w.cmd == CMD_REM_AT && n > 0)
			w.position = 5'($urandom_range(n, 1));
		else
			w.position = 5'($urandom_range(n + 1, 1));
		if (w.cmd == CMD_SEARCH && n > 0 && $urandom_range(1))
			w.value = sb.live_value();
		else if ($urandom_range(1))
			w.value = value_pool[$urandom_range(7)];
		else
			w.value = $urandom;
		return w;
	endfunction

	task automatic send_word(sle_in_t w);
		int gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_command(w);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(logic [4:0] v);
		wait_drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		sb.set_capacity(v);
		cfg_we <= 1'b0;
	endtask

	task automatic run_directed();
		write_capacity(5'd16);
		// empty list: every removal and search fails
		send_word(cmd_word(CMD_SEARCH, 5'd0, 32'h0));
		send_word(cmd_word(CMD_REM_HEAD, 5'd0, 32'h0));
		send_word(cmd_word(CMD_REM_TAIL, 5'd0, 32'h0));
		send_word(cmd_word(CMD_REM_AT, 5'd1, 32'h0));
		send_word(cmd_word(CMD_INS_AT, 5'd0, 32'h1));
		send_word(cmd_word(CMD_INS_AT, 5'd2, 32'h1));
		send_word(cmd_word(CMD_INS_HEAD, 5'd0, 32'h0000_0000));
		send_word(cmd_word(CMD_INS_TAIL, 5'd0, 32'hFFFF_FFFF));
		send_word(cmd_word(CMD_INS_AT, 5'd2, 32'hA5A5_A5A5));
		send_word(cmd_word(CMD_INS_AT, 5'd4, 32'h5A5A_5A5A));
		send_word(cmd_word(CMD_INS_AT, 5'd31, 32'h1));
		send_word(cmd_word(CMD_SEARCH, 5'd31, 32'hFFFF_FFFF));
		send_word(cmd_word(CMD_SEARCH, 5'd0, 32'h0000_0000));
		send_word(cmd_word(CMD_SEARCH, 5'd0, 32'h1234_5678));
		send_word(cmd_word(CMD_REM_AT, 5'd0, 32'h0));
		send_word(cmd_word(CMD_REM_AT, 5'd31, 32'h0));
		send_word(cmd_word(CMD_REM_AT, 5'd4, 32'h0));
		send_word(cmd_word(CMD_REM_AT, 5'd2, 32'h0));
		send_word(cmd_word(CMD_REM_TAIL, 5'd0, 32'h0));
		// stale word past the tail must not match
		send_word(cmd_word(CMD_SEARCH, 5'd0, 32'hFFFF_FFFF));
		send_word(cmd_word(CMD_CLEAR, 5'd0, 32'h0));
		send_word(cmd_word(CMD_SEARCH, 5'd0, 32'h0000_0000));
		write_capacity(5'd2);
		send_word(cmd_word(CMD_INS_HEAD, 5'd0, 32'h1));
		send_word(cmd_word(CMD_INS_HEAD, 5'd0, 32'h2));
		send_word(cmd_word(CMD_INS_TAIL, 5'd0, 32'h3));
		// capacity zero: full and empty at once once cleared
		write_capacity(5'd0);
		send_word(cmd_word(CMD_CLEAR, 5'd0, 32'h0));
		send_word(cmd_word(CMD_INS_TAIL, 5'd0, 32'h4));
	endtask

	initial begin
		logic [4:0] caps [12];
		int         tidy_pct;
		sb = new();
		value_pool[0] = 32'h0000_0000;
		value_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < 8; i++)
			value_pool[i] = $urandom;
		caps = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd5, 5'd17, 5'd3, 5'd9, 5'd2, 5'd16, 5'd12, 5'd24};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 10;
		rx_idle_pct = 73;
		run_directed();

		for (int p = 0; p < 12; p++) begin
			if (p < 4) begin
				tx_idle_pct = 10;
				rx_idle_pct = 73;
			end else if (p < 8) begin
				tx_idle_pct = 73;
				rx_idle_pct = 10;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			write_capacity(caps[p]);
			for (int k = 0; k < PHASE_WORDS; k++) begin
				tidy_pct = 80;
				send_word(make_command($urandom_range(99) < tidy_pct));
				if (p == 1 && k == 60)
					rx_hold_req = 1;
				if (p == 9 && k == 70)
					wait_drain();
			end
		end

		wait_drain();
		if (sb.pending() != 0)
			sb.report("results never arrived", sb.pending(), 0);
		$display("checked %0d result words over 15 capacity settings from 0 to 31", sb.n_checked);
		$display("%0d succeeded, %0d reported full, %0d reported empty",
			sb.n_ok, sb.n_full, sb.n_empty);
		if (sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/sle_pkg.sv
rtl/sle_cell.sv
rtl/sle_find.sv
rtl/sequential_list_engine.sv
rtl/sle_checker.sv
verif/sequential_list_engine_tb.sv
